// ----- hw/rtl/tfr_pkg.sv -----
// Shared types, constants and helpers for the timestamped frame ring.
package tfr_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int MATCH_W = 4;
    localparam int WORD_W  = 32;

    localparam logic [WORD_W-1:0] HALF_RANGE = 32'h8000_0000;
    localparam logic [WORD_W-1:0] GAP_MAX    = 32'h7FFF_FFFF;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FIND   = 1'b1;

    // One stored frame; the last field (stamp) sits in the lowest bits.
    typedef struct packed {
        logic [WORD_W-1:0] accel_z;
        logic [WORD_W-1:0] accel_y;
        logic [WORD_W-1:0] accel_x;
        logic [WORD_W-1:0] quat_z;
        logic [WORD_W-1:0] quat_y;
        logic [WORD_W-1:0] quat_x;
        logic [WORD_W-1:0] quat_w;
        logic [WORD_W-1:0] stamp;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    // Tag that travels with the frame leaving the head of the ring.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [SLOT_W-1:0] idx;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } ctrl_state_t;

    // Magnitude of the wrapped signed difference, saturated at 2^31 - 1.
    function automatic logic [WORD_W-1:0] time_gap(
        input logic [WORD_W-1:0] stored,
        input logic [WORD_W-1:0] query
    );
        logic [WORD_W-1:0] fwd;
        logic [WORD_W-1:0] back;
        logic [WORD_W-1:0] mag;
        fwd  = stored - query;
        back = query - stored;
        mag  = fwd[WORD_W-1] ? back : fwd;
        if (mag == HALF_RANGE)
        begin
            mag = GAP_MAX;
        end
        return mag;
    endfunction

    // Low bits of a slot index as reported on the result.
    function automatic logic [MATCH_W-1:0] match_bits(input logic [SLOT_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[MATCH_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/timestamped_frame_ring_nearest_match.sv -----
// Top level of the timestamped frame ring with nearest-stamp lookup.
//
// Keeps SLOTS (16) attitude frames in a ring of cells, each frame a 32-bit
// timestamp, four quaternion words and three acceleration words kept as raw
// bit patterns. An insert beat (tuser = 0) advances the write slot, wrapping
// after the last slot, and stores the frame there in the cycle it is taken;
// since the write slot resets to 0, the first frame after reset lands in
// slot 1. Slots never written hold zeros and still take part in a search.
// A find beat (tuser = 1) rotates the ring once around, one cell per cycle,
// while a two-stage selector at the head cell measures each stored stamp
// against the query as the magnitude of the wrapped signed 32-bit difference
// (2^31 saturates to 2^31 - 1) and keeps the strictly nearer slot, so the
// lowest slot wins ties. The ring is back in place when the search ends.
// An insert produces no result beat; a find's result beat follows the
// rotation of the ring once around and the two selector stages, and the next
// input beat is accepted in the cycle the result is posted. A finished result
// sits in an output register, so input beats (inserts, and the next find's
// scan) proceed while it waits; a second find's result waits until the first
// has been taken.
module timestamped_frame_ring_nearest_match (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low bit up: stamp, quat_w, quat_x, quat_y, quat_z,
    //                      accel_x, accel_y, accel_z (32 bits each)
    input  logic [255:0] s_tdata,
    // s_tuser: mode (0 insert, 1 find)
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low bit up: match_slot (4), match_stamp, match_quat_w,
    //                      match_quat_x, match_quat_y, match_quat_z,
    //                      match_accel_x, match_accel_y, match_accel_z
    //                      (32 bits each), 4 zero pad bits
    output logic [263:0] m_tdata
);

    localparam int PAD_W = 264 - tfr_pkg::FRAME_W - tfr_pkg::MATCH_W;

    tfr_pkg::ctrl_state_t state_reg, state_next;

    logic [tfr_pkg::SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [tfr_pkg::SLOT_W-1:0] cnt_reg, cnt_next;
    logic [tfr_pkg::SLOT_W-1:0] adv_slot;

    logic                       in_beat;
    logic                       insert_beat;
    logic                       find_beat;
    logic                       shift;
    logic                       scan_end;
    logic                       load_out;

    tfr_pkg::frame_t            in_frame;
    tfr_pkg::frame_t            ring [tfr_pkg::SLOTS];
    tfr_pkg::scan_t             tap;

    logic                       pick_done;
    logic [tfr_pkg::SLOT_W-1:0] pick_idx;
    tfr_pkg::frame_t            pick_frame;

    logic                       out_valid_reg, out_valid_next;
    logic [tfr_pkg::MATCH_W-1:0] out_slot_reg;
    tfr_pkg::frame_t            out_frame_reg;

    assign in_frame    = tfr_pkg::frame_t'(s_tdata);
    assign in_beat     = s_tvalid && s_tready;
    assign insert_beat = in_beat && (s_tuser == tfr_pkg::MODE_INSERT);
    assign find_beat   = in_beat && (s_tuser == tfr_pkg::MODE_FIND);

    // Advance the write slot, wrapping after the last one
    assign adv_slot = (wr_slot_reg == tfr_pkg::SLOT_W'(tfr_pkg::SLOTS - 1))
                      ? '0 : wr_slot_reg + 1'b1;
    assign wr_slot_next = insert_beat ? adv_slot : wr_slot_reg;

    // Ring of cells: cell i takes cell i+1 on each scan cycle
    for (genvar i = 0; i < tfr_pkg::SLOTS; i++)
    begin : g_cell
        tfr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (insert_beat && (adv_slot == tfr_pkg::SLOT_W'(i))),
            .load_frame (in_frame),
            .shift      (shift),
            .shift_in   (ring[(i + 1) % tfr_pkg::SLOTS]),
            .frame      (ring[i])
        );
    end

    // During scan cycle k the head cell holds slot k
    assign scan_end  = (cnt_reg == tfr_pkg::SLOT_W'(tfr_pkg::SLOTS - 1));
    assign tap.valid = shift;
    assign tap.last  = scan_end;
    assign tap.idx   = cnt_reg;

    tfr_pick u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (find_beat),
        .query      (in_frame.stamp),
        .tap        (tap),
        .head       (ring[0]),
        .done       (pick_done),
        .best_idx   (pick_idx),
        .best_frame (pick_frame)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tfr_pkg::ST_IDLE:
            begin
                if (find_beat)
                begin
                    state_next = tfr_pkg::ST_SCAN;
                end
            end
            tfr_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = tfr_pkg::ST_FLUSH;
                end
            end
            tfr_pkg::ST_FLUSH:
            begin
                if (load_out)
                begin
                    state_next = tfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tfr_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready = 1'b0;
        shift    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            tfr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            tfr_pkg::ST_SCAN:
            begin
                shift = 1'b1;
            end
            tfr_pkg::ST_FLUSH:
            begin
                load_out = pick_done && (!out_valid_reg || m_tready);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (shift)
        begin
            cnt_next = scan_end ? '0 : cnt_reg + 1'b1;
        end
    end

    // Output register: hold the result until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_slot_reg  <= tfr_pkg::match_bits(pick_idx);
            out_frame_reg <= pick_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfr_pkg::ST_IDLE;
            wr_slot_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_slot_reg   <= wr_slot_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_frame_reg, out_slot_reg};

endmodule

// ----- hw/rtl/tfr_cell.sv -----
// One ring cell: holds a frame, loads on insert, takes its neighbor's frame on shift.
module tfr_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  tfr_pkg::frame_t load_frame,
    input  logic            shift,
    input  tfr_pkg::frame_t shift_in,
    output tfr_pkg::frame_t frame
);

    tfr_pkg::frame_t frame_reg;
    tfr_pkg::frame_t frame_next;

    always_comb
    begin
        frame_next = frame_reg;
        if (load)
        begin
            frame_next = load_frame;
        end
        else if (shift)
        begin
            frame_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame = frame_reg;

endmodule

// ----- hw/rtl/tfr_pick.sv -----
// Two-stage nearest-stamp selector fed by the head cell of the ring.
module tfr_pick (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tfr_pkg::WORD_W-1:0]    query,
    input  tfr_pkg::scan_t                tap,
    input  tfr_pkg::frame_t               head,
    output logic                          done,
    output logic [tfr_pkg::SLOT_W-1:0]    best_idx,
    output tfr_pkg::frame_t               best_frame
);

    logic [tfr_pkg::WORD_W-1:0] query_reg;
    tfr_pkg::scan_t             tag_reg, tag_next;
    tfr_pkg::frame_t            frame_a_reg;
    logic [tfr_pkg::WORD_W-1:0] gap_a_reg;
    logic [tfr_pkg::WORD_W-1:0] best_gap_reg, best_gap_next;
    logic [tfr_pkg::SLOT_W-1:0] best_idx_reg, best_idx_next;
    tfr_pkg::frame_t            best_frame_reg, best_frame_next;
    logic                       done_reg, done_next;
    logic                       take;

    // Stage A: hold the head frame and its gap
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            query_reg <= query;
        end
        frame_a_reg <= head;
        gap_a_reg   <= tfr_pkg::time_gap(head.stamp, query_reg);
    end

    always_comb
    begin
        tag_next = tap;
        if (start)
        begin
            tag_next = '0;
        end
    end

    // Stage B: keep the strictly nearer entry; slot 0 seeds the search
    assign take = tag_reg.valid
                  && ((tag_reg.idx == '0) || (gap_a_reg < best_gap_reg));

    always_comb
    begin
        best_gap_next   = best_gap_reg;
        best_idx_next   = best_idx_reg;
        best_frame_next = best_frame_reg;
        if (take)
        begin
            best_gap_next   = gap_a_reg;
            best_idx_next   = tag_reg.idx;
            best_frame_next = frame_a_reg;
        end
    end

    always_comb
    begin
        done_next = done_reg;
        if (start)
        begin
            done_next = 1'b0;
        end
        else if (tag_reg.valid && tag_reg.last)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        best_gap_reg   <= best_gap_next;
        best_idx_reg   <= best_idx_next;
        best_frame_reg <= best_frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg  <= tag_next;
            done_reg <= done_next;
        end
    end

    assign done       = done_reg;
    assign best_idx   = best_idx_reg;
    assign best_frame = best_frame_reg;

endmodule

// ----- hw/rtl/tfr_checker.sv -----
// Port-level checker for the timestamped frame ring, bound to the top level.
module tfr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [263:0] m_tdata
);

    // A stalled result beat holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A find keeps the input side busy while the ring rotates
    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == tfr_pkg::MODE_FIND) |=> !s_tready)
        else $error("input accepted during a search");

    // An insert never produces a result beat
    a_insert_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == tfr_pkg::MODE_INSERT) && !m_tvalid
        |=> !m_tvalid)
        else $error("result beat after an insert");

    // Pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[263:260] == 4'b0000))
        else $error("nonzero pad bits on result");

endmodule

bind timestamped_frame_ring_nearest_match tfr_checker u_tfr_checker (.*);

// ----- sim/timestamped_frame_ring_nearest_match_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the timestamped frame ring with nearest-stamp lookup.

// Mirror of the ring: stores inserted frames and predicts every find result.
class frame_ring_tracker;
    tfr_pkg::frame_t            ring [tfr_pkg::SLOTS];
    logic [tfr_pkg::SLOT_W-1:0] write_slot;
    logic [263:0]               awaited_matches [$];
    int                         mismatches;
    int                         matches_checked;
    int                         frames_stored;

    function new();
        write_slot = '0;
        foreach (ring[i])
        begin
            ring[i] = '0;
        end
        mismatches      = 0;
        matches_checked = 0;
        frames_stored   = 0;
    endfunction

    // Magnitude of the wrapped signed difference; the half-range point saturates.
    function logic [31:0] stamp_distance(logic [31:0] stored, logic [31:0] query);
        logic [31:0] diff;
        logic [31:0] mag;
        diff = stored - query;
        mag  = diff[31] ? (32'd0 - diff) : diff;
        if (mag == 32'h8000_0000)
        begin
            mag = 32'h7FFF_FFFF;
        end
        return mag;
    endfunction

    // Note one accepted input beat: store a frame, or queue the predicted match.
    function void take_beat(logic mode, logic [255:0] data);
        tfr_pkg::frame_t beat_frame;
        int              best;
        logic [31:0]     best_gap;
        logic [31:0]     gap;
        beat_frame = data;
        if (mode == tfr_pkg::MODE_INSERT)
        begin
            // Advance first, then write: the first frame after reset goes to slot 1.
            write_slot = (write_slot == tfr_pkg::SLOTS - 1) ? '0 : write_slot + 1'b1;
            ring[write_slot] = beat_frame;
            frames_stored++;
        end
        else
        begin
            best     = 0;
            best_gap = stamp_distance(ring[0].stamp, beat_frame.stamp);
            for (int i = 1; i < tfr_pkg::SLOTS; i++)
            begin
                gap = stamp_distance(ring[i].stamp, beat_frame.stamp);
                // Only a strictly nearer slot wins, so ties keep the lower slot.
                if (gap < best_gap)
                begin
                    best_gap = gap;
                    best     = i;
                end
            end
            awaited_matches.push_back({4'b0000, ring[best], best[3:0]});
        end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // Compare one accepted result beat with the oldest predicted match.
    task check_match(logic [263:0] beat);
        logic [263:0] want;
        string        word_names [8] = '{"match_stamp", "match_quat_w", "match_quat_x",
                                         "match_quat_y", "match_quat_z", "match_accel_x",
                                         "match_accel_y", "match_accel_z"};
        if (awaited_matches.size() == 0)
        begin
            report("result beat with no find pending", beat[35:4], 32'd0);
        end
        else
        begin
            want = awaited_matches.pop_front();
            matches_checked++;
            if (beat[3:0] !== want[3:0])
            begin
                report("match_slot", 32'(beat[3:0]), 32'(want[3:0]));
            end
            for (int k = 0; k < 8; k++)
            begin
                if (beat[4 + 32*k +: 32] !== want[4 + 32*k +: 32])
                begin
                    report(word_names[k], beat[4 + 32*k +: 32], want[4 + 32*k +: 32]);
                end
            end
            if (beat[263:260] !== 4'b0000)
            begin
                report("pad bits", 32'(beat[263:260]), 32'd0);
            end
        end
    endtask
endclass

module timestamped_frame_ring_nearest_match_tb;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // s_tdata, low bit up: stamp, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z
    logic [255:0] s_tdata  = '0;
    // s_tuser: mode (0 insert, 1 find)
    logic         s_tuser  = tfr_pkg::MODE_INSERT;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // m_tdata, low bit up: match_slot (4), match_stamp, match_quat_w .. match_accel_z, pad (4)
    logic [263:0] m_tdata;

    // Percent of cycles in which each side holds off.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int beats_sent    = 0;

    frame_ring_tracker tracker;

    timestamped_frame_ring_nearest_match u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result side at random; a zero percentage keeps tready high.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Sample both handshakes at the edge. Check results before noting new input,
    // so a stray result beat never consumes a prediction made at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            tracker.check_match(m_tdata);
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            tracker.take_beat(s_tuser, s_tdata);
        end
    end

    function automatic logic [223:0] random_payload();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Drive one beat and hold it until accepted. Drop tvalid only when a gap
    // follows, so back-to-back beats keep tvalid high without a glitch.
    task automatic send_beat(input logic mode, input logic [31:0] stamp,
                             input logic [223:0] payload);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {payload, stamp};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    initial
    begin
        logic [31:0] time_base;
        logic [31:0] recent [16];
        logic [31:0] stamp;
        logic [31:0] lo_stamp;
        logic [31:0] hi_stamp;
        int          inserts_sent;
        int          pick;
        int          kind;

        tracker = new();
        foreach (recent[i])
        begin
            recent[i] = '0;
        end
        inserts_sent  = 0;
        send_idle_pct = 32;
        recv_idle_pct = 85;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring: every slot is zero, so all tie and slot 0 wins.
        send_beat(tfr_pkg::MODE_FIND, 32'h0000_0000, '1);
        // Query half a range away from every zero stamp: saturated distances tie.
        send_beat(tfr_pkg::MODE_FIND, 32'h8000_0000, random_payload());
        // First frame lands in slot 1, all ones.
        send_beat(tfr_pkg::MODE_INSERT, 32'hFFFF_FFFF, '1);
        send_beat(tfr_pkg::MODE_FIND, 32'h0000_0000, '0);
        send_beat(tfr_pkg::MODE_FIND, 32'hFFFF_FFFF, random_payload());
        send_beat(tfr_pkg::MODE_INSERT, 32'h8000_0000, '0);
        send_beat(tfr_pkg::MODE_FIND, 32'h8000_0000, random_payload());
        // Quarter range: 4000_0000 ties slots 0 and 2, lower wins; C000_0000 goes to slot 1.
        send_beat(tfr_pkg::MODE_FIND, 32'h4000_0000, random_payload());
        send_beat(tfr_pkg::MODE_FIND, 32'hC000_0000, random_payload());
        send_beat(tfr_pkg::MODE_INSERT, 32'h7FFF_FFFF, {7{32'hA5A5_5A5A}});
        send_beat(tfr_pkg::MODE_FIND, 32'h7FFF_FFFE, random_payload());
        // Fill the rest of the ring and wrap the write slot back over slot 0.
        for (int k = 0; k < 13; k++)
        begin
            send_beat(tfr_pkg::MODE_INSERT, 32'd1000 + 32'(10 * k), random_payload());
        end
        // Exact hit on a wrapped slot, then a query equidistant from two frames.
        send_beat(tfr_pkg::MODE_FIND, 32'd1120, random_payload());
        send_beat(tfr_pkg::MODE_FIND, 32'd1045, random_payload());

        // Random part: a millisecond clock that runs through the 32-bit wrap,
        // frames stamped near it, queries mostly near it with some noise.
        time_base = 32'hFFFF_FE00;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 300; n++)
            begin
                pick = $urandom_range(0, 99);
                kind = $urandom_range(0, 9);
                if (pick < 55)
                begin
                    if (kind == 0)
                    begin
                        stamp = $urandom;
                    end
                    else if (kind == 1)
                    begin
                        // Repeat a stamp already in the ring to force ties.
                        stamp = recent[$urandom_range(0, 15)];
                    end
                    else
                    begin
                        time_base = time_base + $urandom_range(0, 8);
                        stamp     = time_base + $urandom_range(0, 3);
                    end
                    recent[inserts_sent % 16] = stamp;
                    inserts_sent++;
                    send_beat(tfr_pkg::MODE_INSERT, stamp, random_payload());
                end
                else
                begin
                    lo_stamp = recent[$urandom_range(0, 15)];
                    hi_stamp = recent[$urandom_range(0, 15)];
                    case (kind)
                        0: stamp = $urandom;
                        1: stamp = lo_stamp ^ 32'h8000_0000;
                        2: stamp = lo_stamp;
                        3, 4: stamp = lo_stamp + ((hi_stamp - lo_stamp) >> 1);
                        default: stamp = time_base - $urandom_range(0, 80)
                                         + $urandom_range(0, 8);
                    endcase
                    send_beat(tfr_pkg::MODE_FIND, stamp, random_payload());
                end
            end
        end

        s_tvalid <= 1'b0;
        while (tracker.awaited_matches.size() != 0)
        begin
            @(posedge clk);
        end
        // Keep the clock running after the last result to catch any stray result beat.
        repeat (2 * tfr_pkg::SLOTS + 8) @(posedge clk);

        $display("covered %0d input beats: %0d frames stored (ring wrapped %0d times)",
                 beats_sent, tracker.frames_stored, tracker.frames_stored / tfr_pkg::SLOTS);
        $display("checked %0d nearest-stamp matches, %0d mismatches, under three stall mixes",
                 tracker.matches_checked, tracker.mismatches);
        if (tracker.mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("timeout with %0d matches still awaited", tracker.awaited_matches.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_cell.sv
hw/rtl/tfr_pick.sv
hw/rtl/timestamped_frame_ring_nearest_match.sv
hw/rtl/tfr_checker.sv
sim/timestamped_frame_ring_nearest_match_tb.sv
